### rtl/core/mdx_pkg.sv
// mdx_pkg: shared types and constants for the modular division block
// used by mdx_unit and modular_division_ext_euclid; no dependencies
package mdx_pkg;

  localparam int VALUE_WIDTH_DEF = 31;
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_DIV_ZERO = 2'd1;
  localparam status_t ST_NO_INV   = 2'd2;

  typedef logic unit_op_t;

  localparam unit_op_t OP_DIV = 1'b0;
  localparam unit_op_t OP_MUL = 1'b1;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_cmd_t;

  typedef struct packed {
    logic done;
    logic busy;
  } unit_rsp_t;

endpackage

### rtl/core/modular_division_ext_euclid.sv
// modular_division_ext_euclid: dividend times inverse of divisor modulo a configured modulus
// depends on mdx_pkg and mdx_unit
//
// One word is taken at a time. The inverse comes from the extended Euclidean algorithm, run
// on one shared iterative unit that either divides by shift and subtract (one quotient bit per
// cycle after aligning the divisor) or multiplies modulo the modulus by shift and add (one
// multiplier bit per cycle). Each Euclid step runs one divide and one multiply on the unit;
// the quotient bits over all steps add up to at most about VALUE_WIDTH plus the step count,
// with at most about 1.44*VALUE_WIDTH steps. The dividend is then reduced modulo the modulus
// and multiplied by the inverse. A zero divisor or zero modulus skips the unit and goes from
// the init state straight to the output state. The input stalls until the result is in the
// output register; a finished result may wait there while the next word is taken. status:
// 0 ok, 1 divisor zero, 2 no inverse (quotient 0 when status is not ok).
module modular_division_ext_euclid #(
  parameter int VALUE_WIDTH = mdx_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_dividend,
  input  logic [VALUE_WIDTH-1:0] in_divisor,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_quotient,
  output mdx_pkg::status_t       out_status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [VALUE_WIDTH-1:0] cfg_data
);
  import mdx_pkg::*;

  localparam int W = VALUE_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_TEST = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_RED  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]   state_r, state_nxt;
  logic [W-1:0] modulus_r;
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic [W-1:0] m_r, m_nxt;
  logic [W-1:0] r0_r, r0_nxt;
  logic [W-1:0] r1_r, r1_nxt;
  logic [W-1:0] s0_r, s0_nxt;
  logic [W-1:0] s1_r, s1_nxt;
  logic [W-1:0] qt_r, qt_nxt;
  status_t      st_r, st_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_quotient_r, out_quotient_nxt;
  status_t      out_status_r, out_status_nxt;

  unit_cmd_t    cmd;
  unit_rsp_t    rsp;
  logic [W-1:0] opa;
  logic [W-1:0] opb;
  logic [W-1:0] unit_x;
  logic [W-1:0] unit_z;

  logic [W:0]   sdiff;
  logic [W:0]   swrap;
  logic [W-1:0] s_new;
  logic         load_out;

  mdx_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .opa  (opa),
    .opb  (opb),
    .mod  (m_r),
    .rsp  (rsp),
    .res_x(unit_x),
    .res_z(unit_z)
  );

  // s0 - q*s1 mod m
  assign sdiff = {1'b0, s0_r} - {1'b0, unit_x};
  assign swrap = sdiff + {1'b0, m_r};
  assign s_new = sdiff[W] ? swrap[W-1:0] : sdiff[W-1:0];

  assign load_out = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    m_nxt     = m_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    s0_nxt    = s0_r;
    s1_nxt    = s1_r;
    qt_nxt    = qt_r;
    st_nxt    = st_r;
    cmd.start = 1'b0;
    cmd.op    = OP_DIV;
    opa       = r0_r;
    opb       = r1_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          a_nxt     = in_dividend;
          b_nxt     = in_divisor;
          m_nxt     = modulus_r;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        qt_nxt = '0;
        r0_nxt = b_r;
        r1_nxt = m_r;
        s0_nxt = (m_r == W'(1)) ? '0 : W'(1);
        s1_nxt = '0;
        if (b_r == '0) begin
          st_nxt    = ST_DIV_ZERO;
          state_nxt = S_OUT;
        end else if (m_r == '0) begin
          st_nxt    = ST_NO_INV;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (r1_r != '0) begin
          cmd.start = 1'b1;
          state_nxt = S_DIV;
        end else if (r0_r != W'(1)) begin
          st_nxt    = ST_NO_INV;
          state_nxt = S_OUT;
        end else begin
          cmd.start = 1'b1;
          opa       = a_r;
          opb       = m_r;
          state_nxt = S_RED;
        end
      end
      S_DIV: begin
        if (rsp.done) begin
          r0_nxt    = r1_r;
          r1_nxt    = unit_x;
          cmd.start = 1'b1;
          cmd.op    = OP_MUL;
          opa       = s1_r;
          opb       = unit_z;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (rsp.done) begin
          s0_nxt    = s1_r;
          s1_nxt    = s_new;
          state_nxt = S_TEST;
        end
      end
      S_RED: begin
        if (rsp.done) begin
          cmd.start = 1'b1;
          cmd.op    = OP_MUL;
          opa       = unit_x;
          opb       = s0_r;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (rsp.done) begin
          qt_nxt    = unit_x;
          st_nxt    = ST_OK;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_quotient_nxt = out_quotient_r;
    out_status_nxt   = out_status_r;
    if (load_out) begin
      out_valid_nxt    = 1'b1;
      out_quotient_nxt = qt_r;
      out_status_nxt   = st_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= MODULUS_RESET[W-1:0];
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        modulus_r <= cfg_data;
      end
    end
    a_r            <= a_nxt;
    b_r            <= b_nxt;
    m_r            <= m_nxt;
    r0_r           <= r0_nxt;
    r1_r           <= r1_nxt;
    s0_r           <= s0_nxt;
    s1_r           <= s1_nxt;
    qt_r           <= qt_nxt;
    st_r           <= st_nxt;
    out_quotient_r <= out_quotient_nxt;
    out_status_r   <= out_status_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_quotient = out_quotient_r;
  assign out_status   = out_status_r;

`ifndef NO_ASSERTIONS
  ap_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && rsp.done) |-> (unit_x < r1_r))
    else $error("euclid remainder did not shrink");

  ap_quot_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && rsp.done) |-> (unit_x < m_r))
    else $error("quotient not below modulus");

  ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !rsp.busy)
    else $error("unit started while busy");
`endif

endmodule

### rtl/core/mdx_unit.sv
// mdx_unit: shared iterative unit, shift-subtract divide and shift-add modular multiply
// depends on mdx_pkg
module mdx_unit #(
  parameter int VALUE_WIDTH = mdx_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mdx_pkg::unit_cmd_t     cmd,
  input  logic [VALUE_WIDTH-1:0] opa,
  input  logic [VALUE_WIDTH-1:0] opb,
  input  logic [VALUE_WIDTH-1:0] mod,
  output mdx_pkg::unit_rsp_t     rsp,
  output logic [VALUE_WIDTH-1:0] res_x,
  output logic [VALUE_WIDTH-1:0] res_z
);
  import mdx_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(VALUE_WIDTH);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ALIGN = 2'd1;
  localparam logic [1:0] PH_SUB   = 2'd2;
  localparam logic [1:0] PH_MUL   = 2'd3;

  logic [1:0]    ph_r, ph_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [W-1:0]  z_r, z_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;

  logic [W:0]    dbl;
  logic [W:0]    diff;
  logic          ge;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] p, input logic [W-1:0] q,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    logic [W:0] t;
    s = {1'b0, p} + {1'b0, q};
    t = s - {1'b0, m};
    return t[W] ? s[W-1:0] : t[W-1:0];
  endfunction

  assign dbl  = {y_r, 1'b0};
  assign diff = {1'b0, x_r} - {1'b0, y_r};
  assign ge   = ~diff[W];

  always_comb begin
    ph_nxt   = ph_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    unique case (ph_r)
      PH_IDLE: begin
        if (cmd.start) begin
          cnt_nxt = '0;
          if (cmd.op == OP_DIV) begin
            x_nxt  = opa;
            y_nxt  = opb;
            z_nxt  = '0;
            ph_nxt = PH_ALIGN;
          end else begin
            x_nxt  = '0;
            y_nxt  = opa;
            z_nxt  = opb;
            ph_nxt = PH_MUL;
          end
        end
      end
      PH_ALIGN: begin
        if (!y_r[W-1] && (dbl <= {1'b0, x_r})) begin
          y_nxt   = dbl[W-1:0];
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          ph_nxt = PH_SUB;
        end
      end
      PH_SUB: begin
        if (ge) begin
          x_nxt = diff[W-1:0];
        end
        z_nxt = {z_r[W-2:0], ge};
        y_nxt = y_r >> 1;
        if (cnt_r == '0) begin
          ph_nxt   = PH_IDLE;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      PH_MUL: begin
        if (z_r == '0) begin
          ph_nxt   = PH_IDLE;
          done_nxt = 1'b1;
        end else begin
          if (z_r[0]) begin
            x_nxt = add_mod(x_r, y_r, mod);
          end
          y_nxt = add_mod(y_r, y_r, mod);
          z_nxt = z_r >> 1;
        end
      end
      default: begin
        ph_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.busy = (ph_r != PH_IDLE);
  assign res_x    = x_r;
  assign res_z    = z_r;

`ifndef NO_ASSERTIONS
  ap_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (ph_r == PH_IDLE))
    else $error("unit done while still working");

  ap_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_MUL) |-> (x_r < mod))
    else $error("multiply accumulator not reduced");

  ap_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_SUB && cnt_r == '0) |=> (done_r && ph_r == PH_IDLE))
    else $error("divide did not finish after last quotient bit");
`endif

endmodule
